FILE: rtl/cur_pkg.sv
// console serial unit package: item types, command and register codes, constants
// used by the channel interfaces and the core
`default_nettype none

package cur_pkg;

    localparam int unsigned CMD_W      = 2;
    localparam int unsigned SEL_W      = 2;
    localparam int unsigned WDATA_W    = 16;
    localparam int unsigned MS_W       = 32;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CHAR_W     = 7;
    localparam int unsigned GAP_W      = 16;
    localparam int unsigned TICKS_W    = 8;
    localparam int unsigned MAP_W      = 2;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 4;

    localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    localparam logic [SEL_W-1:0] SEL_RX_STATUS = 2'd0;
    localparam logic [SEL_W-1:0] SEL_RX_BUFFER = 2'd1;
    localparam logic [SEL_W-1:0] SEL_TX_STATUS = 2'd2;
    localparam logic [SEL_W-1:0] SEL_TX_BUFFER = 2'd3;

    localparam logic [1:0] CFG_RX_GAP_MS   = 2'd0;
    localparam logic [1:0] CFG_TX_TICKS    = 2'd1;
    localparam logic [1:0] CFG_NEWLINE_MAP = 2'd2;
    localparam logic [1:0] CFG_ERASE_MAP   = 2'd3;

    localparam logic [MAP_W-1:0] NL_CR_TO_LF  = 2'd1;
    localparam logic [MAP_W-1:0] NL_LF_TO_CR  = 2'd2;
    localparam logic [MAP_W-1:0] ER_BS_TO_DEL = 2'd1;
    localparam logic [MAP_W-1:0] ER_DEL_TO_BS = 2'd2;

    localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
    localparam logic [BYTE_W-1:0] CH_DEL = 8'h7F;

    localparam int unsigned BIT_DONE = 7;
    localparam int unsigned BIT_IE   = 6;

    localparam logic [TICKS_W-1:0] TX_TICKS_RESET = 8'd32;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [SEL_W-1:0]   reg_select;
        logic [WDATA_W-1:0] write_data;
        logic [MS_W-1:0]    now_ms;
        logic               host_byte_valid;
        logic [BYTE_W-1:0]  host_byte;
        logic               rx_irq_pending;
    } t_in_item;

    typedef struct packed {
        logic [WDATA_W-1:0] read_data;
        logic               rx_irq;
        logic               tx_irq;
        logic               tx_valid;
        logic [CHAR_W-1:0]  tx_byte;
        logic               host_byte_taken;
        logic               newline_seen;
    } t_out_item;

endpackage

`default_nettype wire

FILE: rtl/cur_if.sv
// valid/ready channel interfaces for the console serial unit
// depends on cur_pkg for the item types
`default_nettype none

interface cur_in_if;
    logic                 valid;
    logic                 ready;
    cur_pkg::t_in_item    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cur_out_if;
    logic                 valid;
    logic                 ready;
    cur_pkg::t_out_item   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/console_uart_registers_core.sv
// console serial unit: receiver/transmitter status and buffer registers
// depends on cur_pkg and the channel interfaces in cur_if
//
// usage:
//   i_in carries items: register read, register write or poll tick. each accepted
//   item gives exactly one result item on o_out (read data, interrupt requests,
//   transmitted byte, host byte consumed, newline seen).
//   an item is accepted when valid and ready are both high.
//   an accepted item is captured in the input register; it is processed when the
//   result register is empty or o_out.ready is high, and its result is then registered
//   in the result register, which drives o_out.valid.
//   throughput: one item per cycle while o_out is not stalled; the state update is a
//   single pass of flag logic between the input register and the result register.
//   when the receiver stalls, the result register holds and the input register
//   still takes one more item; ready drops only when both are full.
//   apb port: rx_gap_ms at 0x0, tx_ticks at 0x4, newline_map at 0x8, erase_map
//   at 0xc; write only while no item is in flight. pready is tied high.
//   reset (synchronous, active low): both stages empty, rx done clear, tx ready set,
//   interrupt enables clear, tx_ticks 32, other settings zero.
`default_nettype none

module console_uart_registers_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    cur_in_if.sink                               i_in,
    cur_out_if.source                            o_out,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [cur_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [cur_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [cur_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready
);

    // configuration
    logic [cur_pkg::GAP_W-1:0]   r_rx_gap_ms;
    logic [cur_pkg::TICKS_W-1:0] r_tx_ticks;
    logic [cur_pkg::MAP_W-1:0]   r_newline_map;
    logic [cur_pkg::MAP_W-1:0]   r_erase_map;

    // pipeline
    logic                  r_in_valid;
    cur_pkg::t_in_item     r_in;
    logic                  r_out_valid;
    cur_pkg::t_out_item    r_out;
    logic                  w_advance;
    logic                  w_accept;

    // unit state
    logic                        r_rx_done,    n_rx_done;
    logic                        r_rx_ie,      n_rx_ie;
    logic [cur_pkg::CHAR_W-1:0]  r_rx_buf,     n_rx_buf;
    logic                        r_tx_ready,   n_tx_ready;
    logic                        r_tx_ie,      n_tx_ie;
    logic [cur_pkg::CHAR_W-1:0]  r_tx_buf,     n_tx_buf;
    logic [cur_pkg::TICKS_W-1:0] r_tx_cnt,     n_tx_cnt;
    logic [cur_pkg::MS_W-1:0]    r_last_ms,    n_last_ms;
    logic                        r_host_idle,  n_host_idle;
    cur_pkg::t_out_item          n_out;

    logic [cur_pkg::MS_W-1:0]    w_elapsed;
    logic                        w_gap_ok;
    logic [cur_pkg::TICKS_W-1:0] w_cnt_inc;
    logic                        w_cfg_wr;

    function automatic logic [cur_pkg::CHAR_W-1:0] map_char(
        input logic [cur_pkg::CHAR_W-1:0] c_in,
        input logic [cur_pkg::MAP_W-1:0]  nl_map,
        input logic [cur_pkg::MAP_W-1:0]  er_map
    );
        logic [cur_pkg::CHAR_W-1:0] c;
        c = c_in;
        if (nl_map == cur_pkg::NL_CR_TO_LF && c == cur_pkg::CH_CR[cur_pkg::CHAR_W-1:0]) begin
            c = cur_pkg::CH_LF[cur_pkg::CHAR_W-1:0];
        end else if (nl_map == cur_pkg::NL_LF_TO_CR
                     && c == cur_pkg::CH_LF[cur_pkg::CHAR_W-1:0]) begin
            c = cur_pkg::CH_CR[cur_pkg::CHAR_W-1:0];
        end
        if (er_map == cur_pkg::ER_BS_TO_DEL && c == cur_pkg::CH_BS[cur_pkg::CHAR_W-1:0]) begin
            c = cur_pkg::CH_DEL[cur_pkg::CHAR_W-1:0];
        end else if (er_map == cur_pkg::ER_DEL_TO_BS
                     && c == cur_pkg::CH_DEL[cur_pkg::CHAR_W-1:0]) begin
            c = cur_pkg::CH_BS[cur_pkg::CHAR_W-1:0];
        end
        return c;
    endfunction

    // handshake
    assign w_advance   = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_advance;
    assign w_accept    = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // apb
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        case (paddr[cur_pkg::APB_ADDR_W-1:2])
            cur_pkg::CFG_RX_GAP_MS:   prdata[cur_pkg::GAP_W-1:0]   = r_rx_gap_ms;
            cur_pkg::CFG_TX_TICKS:    prdata[cur_pkg::TICKS_W-1:0] = r_tx_ticks;
            cur_pkg::CFG_NEWLINE_MAP: prdata[cur_pkg::MAP_W-1:0]   = r_newline_map;
            cur_pkg::CFG_ERASE_MAP:   prdata[cur_pkg::MAP_W-1:0]   = r_erase_map;
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_gap_ms   <= '0;
            r_tx_ticks    <= cur_pkg::TX_TICKS_RESET;
            r_newline_map <= '0;
            r_erase_map   <= '0;
        end else if (w_cfg_wr) begin
            case (paddr[cur_pkg::APB_ADDR_W-1:2])
                cur_pkg::CFG_RX_GAP_MS:   r_rx_gap_ms   <= pwdata[cur_pkg::GAP_W-1:0];
                cur_pkg::CFG_TX_TICKS:    r_tx_ticks    <= pwdata[cur_pkg::TICKS_W-1:0];
                cur_pkg::CFG_NEWLINE_MAP: r_newline_map <= pwdata[cur_pkg::MAP_W-1:0];
                cur_pkg::CFG_ERASE_MAP:   r_erase_map   <= pwdata[cur_pkg::MAP_W-1:0];
                default: ;
            endcase
        end
    end

    // item processing
    assign w_elapsed = r_in.now_ms - r_last_ms;
    assign w_gap_ok  = r_host_idle
                       || (w_elapsed >= {{(cur_pkg::MS_W-cur_pkg::GAP_W){1'b0}}, r_rx_gap_ms});
    assign w_cnt_inc = r_tx_cnt + 1'b1;

    always_comb begin
        n_rx_done   = r_rx_done;
        n_rx_ie     = r_rx_ie;
        n_rx_buf    = r_rx_buf;
        n_tx_ready  = r_tx_ready;
        n_tx_ie     = r_tx_ie;
        n_tx_buf    = r_tx_buf;
        n_tx_cnt    = r_tx_cnt;
        n_last_ms   = r_last_ms;
        n_host_idle = r_host_idle;
        n_out       = '0;

        case (r_in.command)
            cur_pkg::CMD_READ: begin
                case (r_in.reg_select)
                    cur_pkg::SEL_RX_STATUS: begin
                        n_out.read_data[cur_pkg::BIT_DONE] = r_rx_done;
                        n_out.read_data[cur_pkg::BIT_IE]   = r_rx_ie;
                    end
                    cur_pkg::SEL_RX_BUFFER: begin
                        if (r_rx_done) begin
                            n_rx_done = 1'b0;
                            n_out.read_data[cur_pkg::CHAR_W-1:0] = r_rx_buf;
                        end
                    end
                    cur_pkg::SEL_TX_STATUS: begin
                        n_out.read_data[cur_pkg::BIT_DONE] = r_tx_ready;
                        n_out.read_data[cur_pkg::BIT_IE]   = r_tx_ie;
                    end
                    default: ;
                endcase
            end
            cur_pkg::CMD_WRITE: begin
                case (r_in.reg_select)
                    cur_pkg::SEL_RX_STATUS: begin
                        n_out.rx_irq = r_in.write_data[cur_pkg::BIT_IE] && !r_rx_ie && r_rx_done;
                        n_rx_ie      = r_in.write_data[cur_pkg::BIT_IE];
                    end
                    cur_pkg::SEL_TX_STATUS: begin
                        n_out.tx_irq = r_in.write_data[cur_pkg::BIT_IE] && !r_tx_ie && r_tx_ready;
                        n_tx_ie      = r_in.write_data[cur_pkg::BIT_IE];
                    end
                    cur_pkg::SEL_TX_BUFFER: begin
                        n_tx_buf   = r_in.write_data[cur_pkg::CHAR_W-1:0];
                        n_tx_ready = 1'b0;
                        n_tx_cnt   = '0;
                    end
                    default: ;
                endcase
            end
            cur_pkg::CMD_TICK: begin
                if (!r_rx_done && !r_in.rx_irq_pending && w_gap_ok) begin
                    if (r_in.host_byte_valid) begin
                        n_out.newline_seen    = (r_in.host_byte == cur_pkg::CH_LF)
                                                || (r_in.host_byte == cur_pkg::CH_CR);
                        n_out.host_byte_taken = 1'b1;
                        n_out.rx_irq          = r_rx_ie;
                        n_rx_buf    = map_char(r_in.host_byte[cur_pkg::CHAR_W-1:0],
                                               r_newline_map, r_erase_map);
                        n_rx_done   = 1'b1;
                        n_last_ms   = r_in.now_ms;
                        n_host_idle = 1'b0;
                    end else begin
                        n_host_idle = 1'b1;
                    end
                end
                if (!r_tx_ready) begin
                    n_tx_cnt = w_cnt_inc;
                    if (w_cnt_inc > r_tx_ticks) begin
                        n_out.tx_valid = 1'b1;
                        n_out.tx_byte  = r_tx_buf;
                        n_out.tx_irq   = r_tx_ie;
                        n_tx_ready     = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_rx_done   <= 1'b0;
            r_rx_ie     <= 1'b0;
            r_rx_buf    <= '0;
            r_tx_ready  <= 1'b1;
            r_tx_ie     <= 1'b0;
            r_tx_buf    <= '0;
            r_tx_cnt    <= '0;
            r_last_ms   <= '0;
            r_host_idle <= 1'b1;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_rx_done   <= n_rx_done;
                r_rx_ie     <= n_rx_ie;
                r_rx_buf    <= n_rx_buf;
                r_tx_ready  <= n_tx_ready;
                r_tx_ie     <= n_tx_ie;
                r_tx_buf    <= n_tx_buf;
                r_tx_cnt    <= n_tx_cnt;
                r_last_ms   <= n_last_ms;
                r_host_idle <= n_host_idle;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in.data;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire
